### sv/assert_macros.svh
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");
// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### sv/irm_pkg.sv
// Shared types and constants for the raw image moment block.
`default_nettype none

package irm_pkg;

  // Fixed field widths
  localparam int PIX_W   = 8;
  localparam int SIZE_W  = 11;
  localparam int ACC_W   = 57;
  localparam int CMP_W   = 13;
  localparam int M00_W   = 28;
  localparam int M10_W   = 37;
  localparam int M01_W   = 37;
  localparam int M20_W   = 47;
  localparam int M11_W   = 46;
  localparam int M02_W   = 47;
  localparam int M30_W   = 56;
  localparam int M21_W   = 56;
  localparam int M12_W   = 56;
  localparam int M03_W   = 56;
  localparam int NUM_MOM = 10;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 1'b1;

  // Commands from the controller to the datapath; take, the stage valids and emit are qualified by en
  typedef struct packed {
    logic en;          // pipeline advances this cycle
    logic take;        // pixel accepted into stage 1
    logic row_end;     // accepted pixel closes a row
    logic win_end;     // accepted pixel closes the window
    logic sum_valid;   // stage 2 holds a pixel for the row sums
    logic sum_close;   // that pixel closes its row
    logic fold_valid;  // fold stage holds a finished row
    logic acc_valid;   // accumulate stage holds a finished row
    logic emit;        // that row closes the window: load the result
  } cmd_t;

endpackage

`default_nettype wire

### sv/irm_ctrl.sv
// Controller: window counters, size registers, pipeline tags and output handshake.
`default_nettype none

module irm_ctrl
  import irm_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SIZE_W-1:0]    cfg_wr_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0]   x,
  output logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] y,
  output cmd_t                      cmd
);

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int RST_LAST_COL = ((MAX_WIDTH < 1024) ? MAX_WIDTH : 1024) - 1;
  localparam int RST_LAST_ROW = ((MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024) - 1;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'b01,
    ST_FULL  = 2'b10
  } state_t;

  state_t state, state_next;

  logic [XW-1:0] last_col;
  logic [YW-1:0] last_row;
  logic [XW-1:0] col_count;
  logic [YW-1:0] row_count;
  logic [XW-1:0] wr_last_col;
  logic [YW-1:0] wr_last_row;
  logic [CMP_W-1:0] wr_val;

  logic row_end, win_end, en, take;
  logic v1, re1, we1, v2, re2, we2, v3, we3, v4, we4;

  // Clamp a written size to 1..MAX and keep it as the last index
  always_comb begin
    wr_val = CMP_W'(cfg_wr_data);
    if (wr_val == '0) begin
      wr_last_col = '0;
      wr_last_row = '0;
    end else begin
      if (wr_val > CMP_W'(MAX_WIDTH)) begin
        wr_last_col = XW'(MAX_WIDTH - 1);
      end else begin
        wr_last_col = XW'(wr_val - CMP_W'(1));
      end
      if (wr_val > CMP_W'(MAX_HEIGHT)) begin
        wr_last_row = YW'(MAX_HEIGHT - 1);
      end else begin
        wr_last_row = YW'(wr_val - CMP_W'(1));
      end
    end
  end

  // Size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      last_col <= XW'(RST_LAST_COL);
      last_row <= YW'(RST_LAST_ROW);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_WINDOW_WIDTH:  last_col <= wr_last_col;
        REG_WINDOW_HEIGHT: last_row <= wr_last_row;
        default: ;
      endcase
    end
  end

  // Row and window boundaries; pipeline holds only when a second result
  // reaches a still-occupied output register
  assign row_end  = (col_count >= last_col);
  assign win_end  = row_end && (row_count >= last_row);
  assign en       = !(v4 && we4 && (state == ST_FULL) && !out_ready);
  assign take     = in_valid && en;
  assign in_ready = en;
  assign x        = col_count;
  assign y        = row_count;

  // Column and row counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (take) begin
      if (row_end) begin
        col_count <= '0;
        row_count <= win_end ? '0 : row_count + YW'(1);
      end else begin
        col_count <= col_count + XW'(1);
      end
    end
  end

  // Tags that follow each transaction down the datapath stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      re1 <= 1'b0;
      we1 <= 1'b0;
      v2  <= 1'b0;
      re2 <= 1'b0;
      we2 <= 1'b0;
      v3  <= 1'b0;
      we3 <= 1'b0;
      v4  <= 1'b0;
      we4 <= 1'b0;
    end else if (en) begin
      v1  <= take;
      re1 <= row_end;
      we1 <= win_end;
      v2  <= v1;
      re2 <= re1;
      we2 <= we1;
      v3  <= v2 && re2;
      we3 <= we2;
      v4  <= v3;
      we4 <= we3;
    end
  end

  // Commands to the datapath
  always_comb begin
    cmd.en         = en;
    cmd.take       = take;
    cmd.row_end    = row_end;
    cmd.win_end    = win_end;
    cmd.sum_valid  = en && v2;
    cmd.sum_close  = re2;
    cmd.fold_valid = en && v3;
    cmd.acc_valid  = en && v4;
    cmd.emit       = en && v4 && we4;
  end

  // Output register occupancy
  always_comb begin
    state_next = state;
    case (state)
      ST_EMPTY: begin
        if (cmd.emit) state_next = ST_FULL;
      end
      ST_FULL: begin
        if (out_ready && !cmd.emit) state_next = ST_EMPTY;
      end
      default: state_next = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  assign out_valid = (state == ST_FULL);

endmodule

`default_nettype wire

### sv/irm_datapath.sv
// Datapath: pixel products, row sums, row fold products and moment accumulators.
`default_nettype none

module irm_datapath
  import irm_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  input  wire logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0]   x,
  input  wire logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] y,
  input  wire logic [PIX_W-1:0]   pixel,
  output logic [M00_W-1:0]        m00,
  output logic [M10_W-1:0]        m10,
  output logic [M01_W-1:0]        m01,
  output logic [M20_W-1:0]        m20,
  output logic [M11_W-1:0]        m11,
  output logic [M02_W-1:0]        m02,
  output logic [M30_W-1:0]        m30,
  output logic [M21_W-1:0]        m21,
  output logic [M12_W-1:0]        m12,
  output logic [M03_W-1:0]        m03
);

  localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int X2W    = 2 * XW;
  localparam int X3W    = 3 * XW;
  localparam int Y2W    = 2 * YW;
  localparam int Y3W    = 3 * YW;
  localparam int XP_W   = PIX_W + XW;
  localparam int X2P_W  = PIX_W + X2W;
  localparam int X3P_W  = PIX_W + X3W;
  localparam int RP_W   = PIX_W + XW;
  localparam int RXP_W  = PIX_W + 2 * XW;
  localparam int RX2P_W = PIX_W + 3 * XW;
  localparam int RX3P_W = PIX_W + 4 * XW;

  // Running powers of the current column and row
  logic [X2W-1:0] x2;
  logic [X3W-1:0] x3;
  logic [Y2W-1:0] y2;
  logic [Y3W-1:0] y3;

  // Stage 1: captured pixel and coordinates
  logic [PIX_W-1:0] p1;
  logic [XW-1:0]    x_s1;
  logic [X2W-1:0]   x2_s1;
  logic [X3W-1:0]   x3_s1;
  logic [YW-1:0]    y_s1;
  logic [Y2W-1:0]   y2_s1;
  logic [Y3W-1:0]   y3_s1;

  // Stage 2: pixel products
  logic [PIX_W-1:0] p2;
  logic [XP_W-1:0]  xp2;
  logic [X2P_W-1:0] x2p2;
  logic [X3P_W-1:0] x3p2;
  logic [YW-1:0]    y_s2;
  logic [Y2W-1:0]   y2_s2;
  logic [Y3W-1:0]   y3_s2;

  // Row sums and their updated values
  logic [RP_W-1:0]   rs_p,   sum_p;
  logic [RXP_W-1:0]  rs_xp,  sum_xp;
  logic [RX2P_W-1:0] rs_x2p, sum_x2p;
  logic [RX3P_W-1:0] rs_x3p, sum_x3p;

  // Stage 3: finished row waiting to be folded
  logic [RP_W-1:0]   f_p;
  logic [RXP_W-1:0]  f_xp;
  logic [RX2P_W-1:0] f_x2p;
  logic [RX3P_W-1:0] f_x3p;
  logic [YW-1:0]     f_y;
  logic [Y2W-1:0]    f_y2;
  logic [Y3W-1:0]    f_y3;

  logic [YW+RP_W-1:0]    pr_yp;
  logic [YW+RXP_W-1:0]   pr_yxp;
  logic [Y2W+RP_W-1:0]   pr_y2p;
  logic [YW+RX2P_W-1:0]  pr_yx2p;
  logic [Y2W+RXP_W-1:0]  pr_y2xp;
  logic [Y3W+RP_W-1:0]   pr_y3p;

  // Stage 4: row terms, then the window accumulators
  logic [ACC_W-1:0] term    [NUM_MOM];
  logic [ACC_W-1:0] acc     [NUM_MOM];
  logic [ACC_W-1:0] acc_sum [NUM_MOM];

  // Column powers step as (x+1)^2 and (x+1)^3, row powers likewise
  always_ff @(posedge clk) begin
    if (rst) begin
      x2 <= '0;
      x3 <= '0;
      y2 <= '0;
      y3 <= '0;
    end else if (cmd.take) begin
      if (cmd.row_end) begin
        x2 <= '0;
        x3 <= '0;
        if (cmd.win_end) begin
          y2 <= '0;
          y3 <= '0;
        end else begin
          y2 <= y2 + Y2W'({y, 1'b0}) + Y2W'(1);
          y3 <= y3 + Y3W'({y2, 1'b0}) + Y3W'(y2) + Y3W'({y, 1'b0}) + Y3W'(y) + Y3W'(1);
        end
      end else begin
        x2 <= x2 + X2W'({x, 1'b0}) + X2W'(1);
        x3 <= x3 + X3W'({x2, 1'b0}) + X3W'(x2) + X3W'({x, 1'b0}) + X3W'(x) + X3W'(1);
      end
    end
  end

  // Stage 1 capture
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      p1    <= pixel;
      x_s1  <= x;
      x2_s1 <= x2;
      x3_s1 <= x3;
      y_s1  <= y;
      y2_s1 <= y2;
      y3_s1 <= y3;
    end
  end

  // Stage 2 pixel products
  always_ff @(posedge clk) begin
    if (cmd.en) begin
      p2    <= p1;
      xp2   <= x_s1 * p1;
      x2p2  <= x2_s1 * p1;
      x3p2  <= x3_s1 * p1;
      y_s2  <= y_s1;
      y2_s2 <= y2_s1;
      y3_s2 <= y3_s1;
    end
  end

  assign sum_p   = rs_p + RP_W'(p2);
  assign sum_xp  = rs_xp + RXP_W'(xp2);
  assign sum_x2p = rs_x2p + RX2P_W'(x2p2);
  assign sum_x3p = rs_x3p + RX3P_W'(x3p2);

  // Row sums: add, or hand the row to the fold stage and restart
  always_ff @(posedge clk) begin
    if (rst) begin
      rs_p   <= '0;
      rs_xp  <= '0;
      rs_x2p <= '0;
      rs_x3p <= '0;
    end else if (cmd.sum_valid) begin
      if (cmd.sum_close) begin
        rs_p   <= '0;
        rs_xp  <= '0;
        rs_x2p <= '0;
        rs_x3p <= '0;
      end else begin
        rs_p   <= sum_p;
        rs_xp  <= sum_xp;
        rs_x2p <= sum_x2p;
        rs_x3p <= sum_x3p;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_valid && cmd.sum_close) begin
      f_p   <= sum_p;
      f_xp  <= sum_xp;
      f_x2p <= sum_x2p;
      f_x3p <= sum_x3p;
      f_y   <= y_s2;
      f_y2  <= y2_s2;
      f_y3  <= y3_s2;
    end
  end

  // Row weights by powers of y
  assign pr_yp   = f_y * f_p;
  assign pr_yxp  = f_y * f_xp;
  assign pr_y2p  = f_y2 * f_p;
  assign pr_yx2p = f_y * f_x2p;
  assign pr_y2xp = f_y2 * f_xp;
  assign pr_y3p  = f_y3 * f_p;

  always_ff @(posedge clk) begin
    if (cmd.fold_valid) begin
      term[0] <= ACC_W'(f_p);
      term[1] <= ACC_W'(f_xp);
      term[2] <= ACC_W'(pr_yp);
      term[3] <= ACC_W'(f_x2p);
      term[4] <= ACC_W'(pr_yxp);
      term[5] <= ACC_W'(pr_y2p);
      term[6] <= ACC_W'(f_x3p);
      term[7] <= ACC_W'(pr_yx2p);
      term[8] <= ACC_W'(pr_y2xp);
      term[9] <= ACC_W'(pr_y3p);
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_MOM; i++) begin
      acc_sum[i] = acc[i] + term[i];
    end
  end

  // Window accumulators; cleared when the result is loaded into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_MOM; i++) begin
        acc[i] <= '0;
      end
    end else if (cmd.acc_valid) begin
      for (int i = 0; i < NUM_MOM; i++) begin
        acc[i] <= cmd.emit ? '0 : acc_sum[i];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m00 <= M00_W'(acc_sum[0]);
      m10 <= M10_W'(acc_sum[1]);
      m01 <= M01_W'(acc_sum[2]);
      m20 <= M20_W'(acc_sum[3]);
      m11 <= M11_W'(acc_sum[4]);
      m02 <= M02_W'(acc_sum[5]);
      m30 <= M30_W'(acc_sum[6]);
      m21 <= M21_W'(acc_sum[7]);
      m12 <= M12_W'(acc_sum[8]);
      m03 <= M03_W'(acc_sum[9]);
    end
  end

endmodule

`default_nettype wire

### sv/image_raw_moments.sv
// Top level of the raw image moment block: controller, datapath and checks.
//
//   channel   direction  handshake              payload
//   config    in         cfg_wr_en              cfg_index, cfg_wr_data
//   pixel     in         in_valid / in_ready    pixel
//   moments   out        out_valid / out_ready  m00 .. m03
//
// Takes one pixel per cycle while in_ready is high. out_valid rises once the last
// pixel of a window has passed the stage 1 capture, pixel products, row sums, row
// fold products and accumulate stages in turn. in_ready drops only while a
// finished window result sits in the output register and the next one has reached
// the accumulate stage. Reset zeroes the counters, sums and accumulators at once
// and sets both sizes to 1024 (clamped to the maximum).
`default_nettype none
`include "assert_macros.svh"

module image_raw_moments
  import irm_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SIZE_W-1:0]    cfg_wr_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [PIX_W-1:0]     pixel,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [M00_W-1:0]          m00,
  output logic [M10_W-1:0]          m10,
  output logic [M01_W-1:0]          m01,
  output logic [M20_W-1:0]          m20,
  output logic [M11_W-1:0]          m11,
  output logic [M02_W-1:0]          m02,
  output logic [M30_W-1:0]          m30,
  output logic [M21_W-1:0]          m21,
  output logic [M12_W-1:0]          m12,
  output logic [M03_W-1:0]          m03
);

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  cmd_t          cmd;
  logic [XW-1:0] x;
  logic [YW-1:0] y;

  irm_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .x           (x),
    .y           (y),
    .cmd         (cmd)
  );

  irm_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .x     (x),
    .y     (y),
    .pixel (pixel),
    .m00   (m00),
    .m10   (m10),
    .m01   (m01),
    .m20   (m20),
    .m11   (m11),
    .m02   (m02),
    .m30   (m30),
    .m21   (m21),
    .m12   (m12),
    .m03   (m03)
  );

  // Input only stalls behind an unread result
  `ASSERT_IMPLIES(a_stall_needs_result, clk, rst, !in_ready, out_valid)
  // The last pixel of a window returns both counters to the origin
  `ASSERT_NEXT(a_window_restart, clk, rst, cmd.take && cmd.win_end, (x == '0) && (y == '0))
  // A result loaded into the output register is offered next cycle
  `ASSERT_NEXT(a_emit_shows_result, clk, rst, cmd.emit, out_valid)

endmodule

`default_nettype wire
